/* sv/sff_pkg.sv */
// ----------------------------------------------------------------------------
// sff_pkg - shared definitions for the symmetric FIR filter core
// Widths, fixed-point constants and register map of the folded FIR datapath.
// ----------------------------------------------------------------------------
package sff_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 18;
  localparam int FRAC_BITS    = 17;
  localparam int NCOEF        = 8;
  localparam int TAPS_DEFAULT = 15;
  localparam int TAPS_MAX     = 15;

  // Datapath widths: a pre-added pair grows by one bit, a product is the sum
  // of the operand widths, and the sum of eight products needs three more.
  localparam int PAIR_W = SAMPLE_W + 1;
  localparam int PROD_W = PAIR_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(NCOEF);

  // Register port.
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(NCOEF) + 2;
  localparam int IDX_W  = $clog2(NCOEF);

  // Rounding offset (one half in Q1.17) and saturation bounds.
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX_ACC = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN_ACC = -(ACC_W'(1) <<< (SAMPLE_W - 1));

endpackage

/* sv/symmetric_fir_filter_core.sv */
// ----------------------------------------------------------------------------
// symmetric_fir_filter_core - linear-phase symmetric FIR filter
// Folded FIR with pre-adders, Q1.17 coefficients, round-half-up and
// saturation to 24 bits, programmed through an APB-style register port.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload        Word
//  -------   ---------------------  -------------  ------------------------------
//  input     in_valid / in_ready    in_sample      one signed 24-bit sample
//  output    out_valid / out_ready  out_filtered   one filtered 24-bit sample
//  config    psel/penable/pready    paddr, pwdata  one Q1.17 coefficient
//
//  One word is accepted per clock cycle while in_ready is high. There are five
//  register stages: the pre-add is registered when the word is accepted, then
//  multiply, two adder-tree levels and the final add with rounding and
//  saturation each have their own register, the last driving out_filtered.
//  Each pipeline stage moves on whenever the stage after it is empty or moving,
//  so bubbles are squeezed out and a stalled output only holds back input once
//  every stage is full. The first TAPS-1 words after reset only fill the
//  delay line and give no result. Reset is synchronous and clears the fill
//  count, the stage valid flags and the coefficients.
// ----------------------------------------------------------------------------
module symmetric_fir_filter_core
  import sff_pkg::*;
#(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input sample channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_filtered,
  // Coefficient register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  // Number of tap pairs, and number of products including the centre tap
  // when the tap count is odd.
  localparam int HALF  = TAPS / 2;
  localparam int NPROD = (TAPS + 1) / 2;
  localparam int CNT_W = $clog2(TAPS + 1);

  // --------------------------------------------------------------------------
  // Coefficient registers. The word index comes from the address bits above
  // the byte offset; reads return the coefficient sign-extended to 32 bits.
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef_r [NCOEF];
  logic                     cfg_wr;
  logic [IDX_W-1:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = DATA_W'(coef_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      coef_r[cfg_idx] <= pwdata[COEF_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when its
  // contents move on in the same cycle.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5;
  logic in_acc;

  assign adv5     = !out_valid_r || out_ready;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign in_acc   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Delay line, oldest sample at index 0. Its contents before the line is
  // full never reach a result, so it needs no reset.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] line_r   [TAPS];
  logic signed [SAMPLE_W-1:0] line_nxt [TAPS];
  logic [CNT_W-1:0]           fill_r;
  logic [CNT_W-1:0]           fill_nxt;
  logic                       line_full;

  always_comb begin
    for (int j = 0; j < TAPS - 1; j++) begin
      line_nxt[j] = line_r[j + 1];
    end
    line_nxt[TAPS-1] = in_sample;
  end

  assign fill_nxt  = (fill_r == CNT_W'(TAPS)) ? fill_r : fill_r + CNT_W'(1);
  assign line_full = (fill_nxt == CNT_W'(TAPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_r <= line_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pre-add mirror-image samples of the line as it stands after the
  // new sample has been shifted in. The centre sample passes alone.
  // --------------------------------------------------------------------------
  logic signed [PAIR_W-1:0] pair_nxt [NPROD];
  logic signed [PAIR_W-1:0] pair_r   [NPROD];

  for (genvar k = 0; k < NPROD; k++) begin : g_preadd
    if (k < HALF) begin : g_pair
      assign pair_nxt[k] = PAIR_W'(line_nxt[k]) + PAIR_W'(line_nxt[TAPS-1-k]);
    end else begin : g_centre
      assign pair_nxt[k] = PAIR_W'(line_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_acc && line_full;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_acc) begin
      pair_r <= pair_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: one multiplier per product. Unused product slots are zero so
  // the adder tree keeps a fixed shape of eight leaves.
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_nxt [NCOEF];
  logic signed [PROD_W-1:0] prod_r   [NCOEF];

  for (genvar k = 0; k < NCOEF; k++) begin : g_mult
    if (k < NPROD) begin : g_used
      assign prod_nxt[k] = PROD_W'(pair_r[k]) * PROD_W'(coef_r[k]);
    end else begin : g_unused
      assign prod_nxt[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      prod_r <= prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3 and 4: adder tree. The rounding half is folded into stage 4.
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] sum3_r [NCOEF/2];
  logic signed [ACC_W-1:0] sum4_r [NCOEF/4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      for (int i = 0; i < NCOEF / 2; i++) begin
        sum3_r[i] <= ACC_W'(prod_r[2*i]) + ACC_W'(prod_r[2*i+1]);
      end
    end
    if (adv4 && v3_r) begin
      sum4_r[0] <= sum3_r[0] + sum3_r[1] + ROUND_HALF;
      sum4_r[1] <= sum3_r[2] + sum3_r[3];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: final add, arithmetic shift (floor after adding one half gives
  // round half up) and saturation into the output register.
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]    total;
  logic signed [ACC_W-1:0]    rounded;
  logic signed [SAMPLE_W-1:0] filt_nxt;
  logic signed [SAMPLE_W-1:0] filt_r;

  assign total   = sum4_r[0] + sum4_r[1];
  assign rounded = total >>> FRAC_BITS;

  always_comb begin
    priority if (rounded > OUT_MAX_ACC) begin
      filt_nxt = OUT_MAX_ACC[SAMPLE_W-1:0];
    end else if (rounded < OUT_MIN_ACC) begin
      filt_nxt = OUT_MIN_ACC[SAMPLE_W-1:0];
    end else begin
      filt_nxt = rounded[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv5) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5 && v4_r) begin
      filt_r <= filt_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = filt_r;

endmodule
